FILE: rtl/core/anbt_pkg.sv
// Shared types, constants and the NAL header decode for the Annex B tagger.
// No dependencies; used by anbt_line, anbt_queue and annexb_nal_unit_tagger.
package anbt_pkg;

  localparam int LineDepth  = 4;
  localparam int MaxPush    = LineDepth + 1;
  localparam int QueueDepth = MaxPush + 1;

  localparam logic [2:0] CLASS_NONE  = 3'd0;
  localparam logic [2:0] CLASS_VPS   = 3'd1;
  localparam logic [2:0] CLASS_SPS   = 3'd2;
  localparam logic [2:0] CLASS_PPS   = 3'd3;
  localparam logic [2:0] CLASS_OTHER = 3'd4;

  localparam logic [5:0] H264_TYPE_SPS = 6'd7;
  localparam logic [5:0] H264_TYPE_PPS = 6'd8;
  localparam logic [5:0] H265_TYPE_VPS = 6'd32;
  localparam logic [5:0] H265_TYPE_SPS = 6'd33;
  localparam logic [5:0] H265_TYPE_PPS = 6'd34;

  localparam logic MODE_H264 = 1'b0;

  typedef struct packed {
    logic       unit_begin;
    logic [2:0] unit_class;
    logic [5:0] unit_type;
  } tag_t;

  typedef struct packed {
    logic [7:0] data;
    tag_t       tag;
    logic       frame_end;
  } result_t;

  typedef struct packed {
    logic [2:0]               n;
    result_t [MaxPush-1:0]    ent;
  } push_t;

  function automatic tag_t header_tag(input logic mode, input logic [7:0] hdr);
    tag_t t;
    t.unit_begin = 1'b0;
    if (mode == MODE_H264) begin
      t.unit_type = {1'b0, hdr[4:0]};
      if (t.unit_type == H264_TYPE_SPS) t.unit_class = CLASS_SPS;
      else if (t.unit_type == H264_TYPE_PPS) t.unit_class = CLASS_PPS;
      else t.unit_class = CLASS_OTHER;
    end else begin
      t.unit_type = hdr[6:1];
      if (t.unit_type == H265_TYPE_VPS) t.unit_class = CLASS_VPS;
      else if (t.unit_type == H265_TYPE_SPS) t.unit_class = CLASS_SPS;
      else if (t.unit_type == H265_TYPE_PPS) t.unit_class = CLASS_PPS;
      else t.unit_class = CLASS_OTHER;
    end
    return t;
  endfunction

endpackage

FILE: rtl/core/anbt_line.sv
// Four-byte delay line with start code detection and retagging.
// Depends on anbt_pkg; emits up to five results per accepted byte.
module anbt_line (
  input  logic                clk,
  input  logic                rst,
  input  logic                accept,
  input  logic [7:0]          stream_byte,
  input  logic                frame_last,
  input  logic                mode,
  output anbt_pkg::push_t     push
);

  logic [7:0]     bytes [anbt_pkg::LineDepth];
  anbt_pkg::tag_t tags  [anbt_pkg::LineDepth];
  logic [2:0]     count;
  anbt_pkg::tag_t cur;

  anbt_pkg::tag_t    htag;
  anbt_pkg::tag_t    cur_next;
  anbt_pkg::tag_t    tags_r [anbt_pkg::LineDepth];
  anbt_pkg::result_t line   [anbt_pkg::MaxPush];
  logic              hit;
  logic [2:0]        first;

  always_comb begin
    htag = anbt_pkg::header_tag(mode, stream_byte);
    hit = ((count == 3'd3) && bytes[0] == 8'h00 && bytes[1] == 8'h00 && bytes[2] == 8'h01) ||
          ((count == 3'd4) && bytes[1] == 8'h00 && bytes[2] == 8'h00 && bytes[3] == 8'h01);
    // a zero just before 00 00 01 joins the start code
    if (count == 3'd4 && bytes[0] != 8'h00) first = 3'd1;
    else first = 3'd0;
    cur_next = hit ? htag : cur;

    for (int i = 0; i < anbt_pkg::LineDepth; i++) begin
      tags_r[i] = tags[i];
      if (hit && 3'(i) >= first && 3'(i) < count) begin
        tags_r[i] = htag;
        tags_r[i].unit_begin = (3'(i) == first);
      end
    end

    for (int j = 0; j < anbt_pkg::MaxPush; j++) begin
      if (3'(j) < count) begin
        line[j].data = bytes[j % anbt_pkg::LineDepth];
        line[j].tag  = tags_r[j % anbt_pkg::LineDepth];
      end else begin
        line[j].data = stream_byte;
        line[j].tag  = cur_next;
      end
      line[j].frame_end = frame_last && (3'(j) == count);
    end

    for (int j = 0; j < anbt_pkg::MaxPush; j++) push.ent[j] = line[j];
    if (!accept) push.n = 3'd0;
    else if (frame_last) push.n = count + 3'd1;
    else if (count == 3'(anbt_pkg::LineDepth)) push.n = 3'd1;
    else push.n = 3'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 3'd0;
      cur   <= '0;
    end else if (accept) begin
      if (frame_last) begin
        count <= 3'd0;
        cur   <= '0;
      end else begin
        cur <= cur_next;
        if (count == 3'(anbt_pkg::LineDepth)) begin
          count <= count;
        end else begin
          count <= count + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !frame_last) begin
      for (int i = 0; i < anbt_pkg::LineDepth; i++) begin
        if (count == 3'(anbt_pkg::LineDepth)) begin
          bytes[i] <= line[i+1].data;
          tags[i]  <= line[i+1].tag;
        end else begin
          bytes[i] <= line[i].data;
          tags[i]  <= line[i].tag;
        end
      end
    end
  end

endmodule

FILE: rtl/core/anbt_queue.sv
// Six-entry result queue: takes up to five results at once, drains one per cycle while head_ready is high.
// Depends on anbt_pkg.
module anbt_queue (
  input  logic              clk,
  input  logic              rst,
  input  anbt_pkg::push_t   push,
  output logic              room,
  output logic              head_valid,
  input  logic              head_ready,
  output anbt_pkg::result_t head
);

  anbt_pkg::result_t q [anbt_pkg::QueueDepth];
  logic [2:0]        count;

  anbt_pkg::result_t sh [anbt_pkg::QueueDepth];
  anbt_pkg::result_t q_next [anbt_pkg::QueueDepth];
  logic              pop;
  logic [2:0]        cnt_p;
  logic [2:0]        k;

  assign head_valid = (count != 3'd0);
  assign head       = q[0];
  assign room       = (count <= 3'd1);
  assign pop        = head_valid && head_ready;

  always_comb begin
    cnt_p = count - {2'b00, pop};
    for (int j = 0; j < anbt_pkg::QueueDepth; j++) begin
      if (pop && j < anbt_pkg::QueueDepth - 1) sh[j] = q[j+1];
      else sh[j] = q[j];
    end
    for (int j = 0; j < anbt_pkg::QueueDepth; j++) begin
      k = 3'(j) - cnt_p;
      q_next[j] = sh[j];
      if (3'(j) >= cnt_p && k < push.n) q_next[j] = push.ent[k];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 3'd0;
    end else begin
      count <= cnt_p + push.n;
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < anbt_pkg::QueueDepth; j++) q[j] <= q_next[j];
  end

endmodule

FILE: rtl/core/annexb_nal_unit_tagger.sv
// Top level of the Annex B NAL unit tagger: delay line plus result queue.
// Depends on anbt_pkg, anbt_line and anbt_queue.
//
//   channel   handshake              payload
//   -------   --------------------   ------------------------------------------
//   cfg       cfg_valid/cfg_ready    codec_mode
//   byte in   byte_valid/byte_ready  stream_byte, frame_last
//   tag out   tag_valid/tag_ready    out_byte, unit_class, unit_type,
//                                    unit_begin, frame_end
//
// One byte per cycle while tag_ready is high; the line holds four bytes back.
// A frame's last byte flushes up to five results, popped one per cycle on tag_ready;
// byte_ready is low while more than one result waits in the queue.
// Synchronous reset clears the line, queue and codec_mode. cfg_ready is always high.
module annexb_nal_unit_tagger (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic       codec_mode,
  input  logic       byte_valid,
  output logic       byte_ready,
  input  logic [7:0] stream_byte,
  input  logic       frame_last,
  output logic       tag_valid,
  input  logic       tag_ready,
  output logic [7:0] out_byte,
  output logic [2:0] unit_class,
  output logic [5:0] unit_type,
  output logic       unit_begin,
  output logic       frame_end
);

  logic              mode;
  logic              room;
  logic              accept;
  anbt_pkg::push_t   push;
  anbt_pkg::result_t head;

  assign cfg_ready = 1'b1;
  assign byte_ready = room;
  assign accept = byte_valid && room;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= anbt_pkg::MODE_H264;
    end else if (cfg_valid && cfg_ready) begin
      mode <= codec_mode;
    end
  end

  anbt_line u_line (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .stream_byte(stream_byte),
    .frame_last (frame_last),
    .mode       (mode),
    .push       (push)
  );

  anbt_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .head_valid(tag_valid),
    .head_ready(tag_ready),
    .head      (head)
  );

  assign out_byte   = head.data;
  assign unit_class = head.tag.unit_class;
  assign unit_type  = head.tag.unit_type;
  assign unit_begin = head.tag.unit_begin;
  assign frame_end  = head.frame_end;

endmodule

FILE: dv/nal_tag_checker.sv
// Tag checker for the Annex B NAL unit tagger: predicts every tagged byte and
// compares each tag transaction against the oldest prediction. Depends on anbt_pkg.
module nal_tag_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        codec_mode,
  input  logic        byte_valid,
  input  logic        byte_ready,
  input  logic [7:0]  stream_byte,
  input  logic        frame_last,
  input  logic        tag_valid,
  input  logic        tag_ready,
  input  logic [7:0]  out_byte,
  input  logic [2:0]  unit_class,
  input  logic [5:0]  unit_type,
  input  logic        unit_begin,
  input  logic        frame_end,
  output int unsigned mismatches,
  output int unsigned pending,
  output int unsigned checked
);

  logic [7:0]        line_byte [anbt_pkg::LineDepth];
  anbt_pkg::tag_t    line_tag  [anbt_pkg::LineDepth];
  int                line_fill;
  anbt_pkg::tag_t    open_unit;
  logic              mode_now;
  anbt_pkg::result_t tags_due [$];
  anbt_pkg::result_t want;
  int unsigned       n_bad;
  int unsigned       n_seen;

  function automatic anbt_pkg::tag_t decode_header(input logic m, input logic [7:0] h);
    anbt_pkg::tag_t t;
    t.unit_begin = 1'b0;
    if (m == anbt_pkg::MODE_H264) begin
      t.unit_type = {1'b0, h[4:0]};
      case (t.unit_type)
        anbt_pkg::H264_TYPE_SPS: t.unit_class = anbt_pkg::CLASS_SPS;
        anbt_pkg::H264_TYPE_PPS: t.unit_class = anbt_pkg::CLASS_PPS;
        default:                 t.unit_class = anbt_pkg::CLASS_OTHER;
      endcase
    end else begin
      t.unit_type = h[6:1];
      case (t.unit_type)
        anbt_pkg::H265_TYPE_VPS: t.unit_class = anbt_pkg::CLASS_VPS;
        anbt_pkg::H265_TYPE_SPS: t.unit_class = anbt_pkg::CLASS_SPS;
        anbt_pkg::H265_TYPE_PPS: t.unit_class = anbt_pkg::CLASS_PPS;
        default:                 t.unit_class = anbt_pkg::CLASS_OTHER;
      endcase
    end
    return t;
  endfunction

  task automatic release_byte(input logic [7:0] b, input anbt_pkg::tag_t t, input logic fe);
    anbt_pkg::result_t r;
    r.data      = b;
    r.tag       = t;
    r.frame_end = fe;
    tags_due.insert(tags_due.size(), r);
  endtask

  task automatic take_byte(input logic [7:0] b, input logic last);
    anbt_pkg::tag_t t;
    int   first;
    int   i;
    // 00 00 01 held at the tail: this byte is the header
    if (line_fill >= 3 && line_byte[line_fill-3] == 8'h00 &&
        line_byte[line_fill-2] == 8'h00 && line_byte[line_fill-1] == 8'h01) begin
      t     = decode_header(mode_now, b);
      first = line_fill - 3;
      if (line_fill == anbt_pkg::LineDepth && line_byte[0] == 8'h00) first = 0;
      for (i = first; i < line_fill; i++) line_tag[i] = t;
      line_tag[first].unit_begin = 1'b1;
      open_unit = t;
    end
    if (line_fill == anbt_pkg::LineDepth) begin
      release_byte(line_byte[0], line_tag[0], 1'b0);
      for (i = 1; i < anbt_pkg::LineDepth; i++) begin
        line_byte[i-1] = line_byte[i];
        line_tag[i-1]  = line_tag[i];
      end
      line_fill = anbt_pkg::LineDepth - 1;
    end
    line_byte[line_fill] = b;
    line_tag[line_fill]  = open_unit;
    line_fill++;
    if (last) begin
      for (i = 0; i < line_fill; i++)
        release_byte(line_byte[i], line_tag[i], i + 1 == line_fill);
      for (i = 0; i < anbt_pkg::LineDepth; i++) begin
        line_byte[i] = '0;
        line_tag[i]  = '0;
      end
      open_unit = '0;
      line_fill = 0;
    end
  endtask

  function automatic int unsigned field_diff(input string name, input logic [7:0] exp_v,
                                             input logic [7:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, got_v);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      line_fill = 0;
      open_unit = '0;
      mode_now  = anbt_pkg::MODE_H264;
      tags_due.delete();
      foreach (line_byte[i]) begin
        line_byte[i] = '0;
        line_tag[i]  = '0;
      end
    end else begin
      if (byte_valid && byte_ready) take_byte(stream_byte, frame_last);
      if (cfg_valid && cfg_ready) mode_now = codec_mode;
      if (tag_valid && tag_ready) begin
        if (tags_due.size() == 0) begin
          n_bad++;
          $display("%0t: tag transaction with nothing expected, expected none, actual byte %0h",
                   $time, out_byte);
        end else begin
          want = tags_due[0];
          tags_due.delete(0);
          n_seen++;
          n_bad += field_diff("out_byte", want.data, out_byte);
          n_bad += field_diff("unit_class", 8'(want.tag.unit_class), 8'(unit_class));
          n_bad += field_diff("unit_type", 8'(want.tag.unit_type), 8'(unit_type));
          n_bad += field_diff("unit_begin", 8'(want.tag.unit_begin), 8'(unit_begin));
          n_bad += field_diff("frame_end", 8'(want.frame_end), 8'(frame_end));
        end
      end
    end
    mismatches <= n_bad;
    pending    <= tags_due.size();
    checked    <= n_seen;
  end

endmodule

FILE: dv/annexb_nal_unit_tagger_tb.sv
// Testbench top for annexb_nal_unit_tagger: drives frames of Annex B bytes and
// codec mode writes, stalls the tag side, and reports the verdict.
// Depends on anbt_pkg, the tagger RTL and nal_tag_checker.
module annexb_nal_unit_tagger_tb;

  localparam int IdleLimit    = 4000;
  localparam int SettleCycles = 8;
  localparam int RandomItems  = 400;
  localparam int PhaseItems   = 72;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic       codec_mode = anbt_pkg::MODE_H264;
  logic       byte_valid = 1'b0;
  logic       byte_ready;
  logic [7:0] stream_byte = 8'h00;
  logic       frame_last = 1'b0;
  logic       tag_valid;
  logic       tag_ready = 1'b0;
  logic [7:0] out_byte;
  logic [2:0] unit_class;
  logic [5:0] unit_type;
  logic       unit_begin;
  logic       frame_end;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned checked;

  logic        draining = 1'b0;
  logic [7:0]  frame_q [$];
  int unsigned burst_left = 0;
  int unsigned bytes_sent = 0;
  int unsigned frames_sent = 0;
  int unsigned mode_writes = 0;
  int unsigned idle_cycles = 0;
  int unsigned ready_count = 0;
  int unsigned ready_style = 0;

  always #1 clk = ~clk;

  annexb_nal_unit_tagger u_top (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .codec_mode (codec_mode),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .stream_byte(stream_byte),
    .frame_last (frame_last),
    .tag_valid  (tag_valid),
    .tag_ready  (tag_ready),
    .out_byte   (out_byte),
    .unit_class (unit_class),
    .unit_type  (unit_type),
    .unit_begin (unit_begin),
    .frame_end  (frame_end)
  );

  nal_tag_checker u_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .codec_mode (codec_mode),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .stream_byte(stream_byte),
    .frame_last (frame_last),
    .tag_valid  (tag_valid),
    .tag_ready  (tag_ready),
    .out_byte   (out_byte),
    .unit_class (unit_class),
    .unit_type  (unit_type),
    .unit_begin (unit_begin),
    .frame_end  (frame_end),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked)
  );

  // tag side: ready follows one of four stall styles, picked at random
  always @(posedge clk) begin : recv_pattern
    logic r;
    if (ready_count % 64 == 0) ready_style <= $urandom_range(0, 3);
    case (ready_style)
      0:       r = 1'b1;
      1:       r = 1'($urandom_range(0, 1));
      2:       r = ($urandom_range(0, 3) == 0);
      default: r = (ready_count % 7) < 4;
    endcase
    tag_ready   <= draining || r;
    ready_count <= ready_count + 1;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((byte_valid && byte_ready) || (tag_valid && tag_ready) || (cfg_valid && cfg_ready))
        idle_cycles <= 0;
      else if (idle_cycles + 1 >= IdleLimit) begin
        $display("%0t: no transaction for %0d cycles", $time, IdleLimit);
        $display("annexb_nal_unit_tagger_tb NOT OK");
        $finish;
      end else
        idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        byte_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    byte_valid  <= 1'b1;
    stream_byte <= b;
    frame_last  <= last;
    @(posedge clk);
    while (!byte_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_frame();
    int i;
    for (i = 0; i < frame_q.size(); i++) send_byte(frame_q[i], i == frame_q.size() - 1);
    frames_sent++;
  endtask

  task automatic settle();
    byte_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_mode(input logic m);
    cfg_valid  <= 1'b1;
    codec_mode <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    mode_writes++;
  endtask

  task automatic append_byte(input logic [7:0] b);
    frame_q.insert(frame_q.size(), b);
  endtask

  // zeros and ones often, so stray start codes turn up inside payloads
  function automatic logic [7:0] filler_byte();
    case ($urandom_range(0, 19))
      0, 1, 2, 3: return 8'h00;
      4:          return 8'h01;
      default:    return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] pick_header(input logic m);
    logic [5:0] ty;
    logic [7:0] h;
    if (m == anbt_pkg::MODE_H264) begin
      case ($urandom_range(0, 9))
        0, 1:    ty = anbt_pkg::H264_TYPE_SPS;
        2, 3:    ty = anbt_pkg::H264_TYPE_PPS;
        default: ty = 6'($urandom_range(0, 31));
      endcase
      h[4:0] = ty[4:0];
      h[7:5] = 3'($urandom_range(0, 7));
    end else begin
      case ($urandom_range(0, 9))
        0, 1:    ty = anbt_pkg::H265_TYPE_VPS;
        2, 3:    ty = anbt_pkg::H265_TYPE_SPS;
        4, 5:    ty = anbt_pkg::H265_TYPE_PPS;
        default: ty = 6'($urandom_range(0, 63));
      endcase
      h[6:1] = ty;
      h[7]   = 1'($urandom_range(0, 1));
      h[0]   = 1'($urandom_range(0, 1));
    end
    return h;
  endfunction

  task automatic build_frame(input logic m);
    frame_q.delete();
    if ($urandom_range(0, 9) == 0) begin
      repeat ($urandom_range(1, 12)) append_byte(filler_byte());
      return;
    end
    if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) append_byte(filler_byte());
    repeat ($urandom_range(1, 4)) begin
      case ($urandom_range(0, 7))
        0, 1:    append_byte(8'h00);
        2:       repeat ($urandom_range(2, 4)) append_byte(8'h00);
        default: ;
      endcase
      append_byte(8'h00);
      append_byte(8'h00);
      append_byte(8'h01);
      append_byte(pick_header(m));
      repeat ($urandom_range(0, 10)) append_byte(filler_byte());
    end
    // sometimes a start code cut off by the frame end
    case ($urandom_range(0, 9))
      0: begin
        append_byte(8'h00);
        append_byte(8'h00);
        append_byte(8'h01);
      end
      1: begin
        append_byte(8'h00);
        append_byte(8'h00);
      end
      2:       append_byte(8'h00);
      default: ;
    endcase
  endtask

  initial begin : stimulus
    int unsigned random_base;
    int unsigned phase_start;
    logic        phase_mode;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_mode(anbt_pkg::MODE_H264);
    settle();

    // leading junk, four-byte start, SPS, PPS, start code with no header at the end
    frame_q = '{8'h55, 8'h00, 8'h00, 8'h00, 8'h01, 8'h67, 8'h00, 8'h00, 8'h01, 8'h68,
                8'h00, 8'h00, 8'h01};
    send_frame();
    settle();

    // header 00 that opens the next start code, mode switch inside the frame
    frame_q = '{8'h00, 8'h00, 8'h01, 8'h00, 8'h00, 8'h01};
    foreach (frame_q[i]) send_byte(frame_q[i], 1'b0);
    settle();
    write_mode(~anbt_pkg::MODE_H264);
    frame_q = '{8'h40, 8'hFF};
    send_frame();
    settle();

    // long zero run before a start code, H.265 SPS then PPS on the last byte
    frame_q = '{8'h00, 8'h00, 8'h00, 8'h00, 8'h01, 8'h42, 8'h00, 8'h00, 8'h01, 8'h44};
    send_frame();

    phase_mode  = ~anbt_pkg::MODE_H264;
    random_base = bytes_sent;
    while (bytes_sent - random_base < RandomItems) begin
      settle();
      phase_mode = ~phase_mode;
      write_mode(phase_mode);
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PhaseItems &&
             bytes_sent - random_base < RandomItems) begin
        build_frame(phase_mode);
        send_frame();
      end
    end

    draining <= 1'b1;
    settle();
    $display("Drove %0d bytes in %0d frames across %0d codec mode writes (H.264 and H.265).",
             bytes_sent, frames_sent, mode_writes);
    $display("Compared %0d tagged bytes, %0d mismatches.", checked, mismatches);
    if (mismatches == 0 && pending == 0)
      $display("annexb_nal_unit_tagger_tb OK");
    else
      $display("annexb_nal_unit_tagger_tb NOT OK");
    $finish;
  end

endmodule
